FILE: sv/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern search core.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PATTERN_MAX = 256;
  localparam int LEN_W       = 9;
  localparam int ADDR_W      = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  // item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] slot_index;
    logic [7:0] pattern_byte;
    logic       is_wildcard;
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  // result as the front end classifies it: offset not yet based
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] offset;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } q_wr_t;

endpackage

FILE: sv/wbps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_front
// Accepts load and scan transactions, holds the pattern cells and the
// partial match vector, and classifies each scan byte into a result.
// ----------------------------------------------------------------------------
module wbps_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  wbps_pkg::in_item_t           item,
  input  logic [wbps_pkg::LEN_W-1:0]   pattern_length,
  output wbps_pkg::q_wr_t              q_wr
);

  logic [7:0]                         exp_r  [wbps_pkg::PATTERN_MAX];
  logic                               wild_r [wbps_pkg::PATTERN_MAX];
  logic [wbps_pkg::PATTERN_MAX-1:0]   pm_r, pm_nxt;
  logic [wbps_pkg::ADDR_W-1:0]        seen_r, seen_nxt;
  logic                               fin_r, fin_nxt;
  logic [wbps_pkg::LEN_W-1:0]         len_eff;
  logic [wbps_pkg::LEN_W-1:0]         len_m1;
  logic                               hit;
  logic                               scan;
  logic                               load;

  assign scan = accept && (item.op == wbps_pkg::OP_SCAN);
  assign load = accept && (item.op == wbps_pkg::OP_LOAD);

  // pattern cells, each written only when its slot is addressed
  always_ff @(posedge clk) begin
    for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
      if (load && (32'(item.slot_index) == j)) begin
        exp_r[j]  <= item.pattern_byte;
        wild_r[j] <= item.is_wildcard;
      end
    end
  end

  always_comb begin
    if (32'(pattern_length) > wbps_pkg::PATTERN_MAX) begin
      len_eff = wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX);
    end else begin
      len_eff = pattern_length;
    end
    len_m1 = len_eff - 1'b1;
  end

  // shift-and step: position j extends a partial match ending at j-1
  always_comb begin
    for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
      pm_nxt[j] = (wild_r[j] || (exp_r[j] == item.data_byte)) &&
                  ((j == 0) ? 1'b1 : pm_r[(j == 0) ? 0 : j - 1]);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
      hit = hit | ((32'(len_eff) == j + 1) & pm_nxt[j]);
    end
  end

  always_comb begin
    q_wr.push         = 1'b0;
    q_wr.res.found    = hit;
    q_wr.res.offset   = seen_r - wbps_pkg::ADDR_W'(len_m1);
    if (scan && !fin_r) begin
      q_wr.push = hit || item.is_last;
    end
    if (!hit) begin
      q_wr.res.offset = '0;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    fin_nxt  = fin_r;
    if (scan) begin
      if (item.is_last) begin
        seen_nxt = '0;
        fin_nxt  = 1'b0;
      end else if (!fin_r) begin
        seen_nxt = seen_r + 1'b1;
        fin_nxt  = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r   <= '0;
      seen_r <= '0;
      fin_r  <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      fin_r  <= fin_nxt;
      if (scan) begin
        if (item.is_last) begin
          pm_r <= '0;
        end else if (!fin_r) begin
          pm_r <= pm_nxt;
        end
      end
    end
  end

endmodule

FILE: sv/wbps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_queue
// Short result queue between the front end and the back end.
// ----------------------------------------------------------------------------
module wbps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  wbps_pkg::q_wr_t  q_wr,
  input  logic             rd,
  output wbps_pkg::res_t   rd_res,
  output logic             full,
  output logic             empty
);

  wbps_pkg::res_t              mem_r [wbps_pkg::Q_DEPTH];
  logic [wbps_pkg::Q_AW-1:0]   wp_r, rp_r;
  logic [wbps_pkg::Q_AW:0]     cnt_r;
  logic                        do_wr, do_rd;

  assign full   = (32'(cnt_r) == wbps_pkg::Q_DEPTH);
  assign empty  = (cnt_r == '0);
  assign do_wr  = q_wr.push && !full;
  assign do_rd  = rd && !empty;
  assign rd_res = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= q_wr.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (do_wr ? 1'b1 : 1'b0) - (do_rd ? 1'b1 : 1'b0);
    end
  end

endmodule

FILE: sv/wbps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_back
// Takes classified results, adds the base address and holds the result
// in an output register until it is popped.
// ----------------------------------------------------------------------------
module wbps_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wbps_pkg::res_t                q_res,
  input  logic                          q_empty,
  output logic                          q_rd,
  input  logic [wbps_pkg::ADDR_W-1:0]   base_address,
  input  logic                          out_pop,
  output logic                          out_empty,
  output wbps_pkg::out_item_t           out_item
);

  logic                   valid_r, valid_nxt;
  wbps_pkg::out_item_t    item_r, item_nxt;

  assign q_rd      = (!valid_r || out_pop) && !q_empty;
  assign out_empty = !valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt              = valid_r;
    item_nxt.found         = q_res.found;
    item_nxt.match_address = q_res.found ? (base_address + q_res.offset) : '0;
    if (q_rd) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

FILE: sv/wildcard_byte_pattern_search_core.sv
`timescale 1ns / 1ps
// Output path: a result passes through the result queue and then the output
//   register to the output ports, and waits in the queue behind older unpopped results.
// Throughput: one transaction per cycle; the input stalls only when the
//   four-entry result queue fills behind an unpopped output.
// Reset (rst_n low, synchronous): clears the match vector, byte count,
//   queue and registers; pattern slots are undefined until loaded.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core
// Finds the first occurrence of a wildcard byte pattern in a byte stream.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  wbps_pkg::in_item_t              in_item,
  output logic                            out_empty,
  input  logic                            out_pop,
  output wbps_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wbps_pkg::ADDR_W-1:0]     cfg_wdata
);

  logic [wbps_pkg::LEN_W-1:0]   pattern_length_r;
  logic [wbps_pkg::ADDR_W-1:0]  base_address_r;
  logic                         accept;
  wbps_pkg::q_wr_t              q_wr;
  wbps_pkg::res_t               q_res;
  logic                         q_empty;
  logic                         q_rd;

  assign accept = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      base_address_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        wbps_pkg::CFG_PATTERN_LENGTH: begin
          pattern_length_r <= cfg_wdata[wbps_pkg::LEN_W-1:0];
        end
        wbps_pkg::CFG_BASE_ADDRESS: begin
          base_address_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  wbps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .item           (in_item),
    .pattern_length (pattern_length_r),
    .q_wr           (q_wr)
  );

  wbps_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .rd     (q_rd),
    .rd_res (q_res),
    .full   (in_full),
    .empty  (q_empty)
  );

  wbps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_res        (q_res),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .base_address (base_address_r),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_item     (out_item)
  );

endmodule

FILE: tb/wildcard_byte_pattern_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core_tb
// Drives pattern loads and byte streams into the search core and checks every
// reported match or miss against a cycle-free prediction of the search.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core_tb;
  import wbps_pkg::*;

  // prediction of the search plus the queue of results still owed by the core
  class match_scoreboard;
    bit [7:0]             slot_byte [PATTERN_MAX];
    bit                   slot_wild [PATTERN_MAX];
    bit [PATTERN_MAX-1:0] partial;
    bit [ADDR_W-1:0]      stream_offset;
    bit                   match_done;
    bit [LEN_W-1:0]       pattern_len;
    bit [ADDR_W-1:0]      base_addr;
    out_item_t            expected_matches[$];
    int errors, loads, scans, results, hits;

    function void restart_stream();
      partial       = '0;
      stream_offset = '0;
      match_done    = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      if (idx == CFG_PATTERN_LENGTH) begin
        pattern_len = val[LEN_W-1:0];
      end else begin
        base_addr = val;
      end
    endfunction

    function void note_item(in_item_t it);
      bit [PATTERN_MAX-1:0] pos_ok;
      int                   eff_len;
      out_item_t            r;
      if (it.op == OP_LOAD) begin
        loads++;
        slot_byte[it.slot_index] = it.pattern_byte;
        slot_wild[it.slot_index] = it.is_wildcard;
        return;
      end
      scans++;
      if (match_done) begin
        if (it.is_last) restart_stream();
        return;
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
        pos_ok[j] = slot_wild[j] || (slot_byte[j] == it.data_byte);
      end
      partial = {partial[PATTERN_MAX-2:0], 1'b1} & pos_ok;
      eff_len = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
      if (eff_len > 0 && partial[eff_len-1]) begin
        r.found         = 1'b1;
        r.match_address = base_addr + stream_offset - ADDR_W'(eff_len - 1);
        match_done      = 1'b1;
        expected_matches.push_back(r);
      end else if (it.is_last) begin
        r = '0;
        expected_matches.push_back(r);
      end
      stream_offset++;
      if (it.is_last) restart_stream();
    endfunction

    function void check_match(out_item_t got);
      out_item_t want;
      results++;
      if (got.found) hits++;
      if (expected_matches.size() == 0) begin
        errors++;
        $display("%0t unexpected result: found=%0b address=%h", $time, got.found,
                 got.match_address);
        return;
      end
      want = expected_matches.pop_front();
      if (got.found !== want.found) begin
        errors++;
        $display("%0t found mismatch: expected %0b actual %0b", $time, want.found, got.found);
      end
      if (got.match_address !== want.match_address) begin
        errors++;
        $display("%0t match_address mismatch: expected %h actual %h", $time,
                 want.match_address, got.match_address);
      end
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_item_t             in_item   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PATTERN_LENGTH;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  match_scoreboard sb = new();
  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  bit  rx_hold      = 1'b0;
  int  random_items = 0;

  wildcard_byte_pattern_search_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver side: pop decision at the falling edge, transaction check at the rising
  always @(negedge clk) begin
    out_pop = !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_match(out_item);
  end

  task automatic hold_receiver(input int cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  function automatic in_item_t load_item(input int slot, input int pbyte, input bit wild);
    in_item_t it;
    it.op           = OP_LOAD;
    it.slot_index   = slot[7:0];
    it.pattern_byte = pbyte[7:0];
    it.is_wildcard  = wild;
    it.data_byte    = 8'($urandom_range(255));
    it.is_last      = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_item_t scan_item(input int dbyte, input bit last);
    in_item_t it;
    it.op           = OP_SCAN;
    it.slot_index   = 8'($urandom_range(255));
    it.pattern_byte = 8'($urandom_range(255));
    it.is_wildcard  = 1'($urandom_range(1));
    it.data_byte    = dbyte[7:0];
    it.is_last      = last;
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_item = it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // wait until every owed result is out, then let the core idle with no input pushed
  task automatic settle();
    in_push = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    sb.write_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // idle mix follows the share of random transactions sent so far
  task automatic set_phase();
    case (random_items * 4 / 900)
      0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1:       begin tx_idle_pct = 72; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 72; end
      default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
    endcase
  endtask

  // one stream, optionally with the whole pattern planted at a random offset
  task automatic run_stream(input int eff_len, input int n, input bit plant, input bit close);
    bit [7:0] stream_q[$];
    int       p;
    for (int k = 0; k < n; k++) begin
      if (eff_len > 0 && $urandom_range(1))
        stream_q.push_back(sb.slot_byte[$urandom_range(eff_len - 1)]);
      else
        stream_q.push_back(8'($urandom_range(255)));
    end
    if (plant && eff_len > 0 && n >= eff_len) begin
      p = $urandom_range(n - eff_len);
      for (int k = 0; k < eff_len; k++)
        stream_q[p+k] = sb.slot_wild[k] ? 8'($urandom_range(255)) : sb.slot_byte[k];
    end
    for (int k = 0; k < n; k++) begin
      set_phase();
      if ($urandom_range(99) < 4) begin
        push_item(load_item($urandom_range(255), $urandom_range(255),
                            1'($urandom_range(1))));
        random_items++;
      end
      push_item(scan_item(stream_q[k], close && k == n - 1));
      random_items++;
    end
  endtask

  task automatic run_round(input int round_no);
    int              len_cfg;
    int              eff_len;
    int              pick;
    int              n_streams;
    int              n;
    bit              long_round;
    logic [ADDR_W-1:0] base_v;
    settle();
    set_phase();
    long_round = (round_no == 2);
    pick = $urandom_range(99);
    // full pattern when round_no is 2, at times through a length that saturates
    if (round_no == 2)      len_cfg = $urandom_range(1) ? PATTERN_MAX : 511;
    else if (pick < 8)      len_cfg = 0;
    else if (pick < 75)     len_cfg = $urandom_range(1, 6);
    else if (pick < 95)     len_cfg = $urandom_range(7, 24);
    else                    len_cfg = $urandom_range(25, 64);
    eff_len = (len_cfg > PATTERN_MAX) ? PATTERN_MAX : len_cfg;
    pick = $urandom_range(99);
    if (pick < 15)      base_v = '0;
    else if (pick < 30) base_v = '1 - ADDR_W'($urandom_range(40));
    else                base_v = {$urandom, $urandom};
    cfg_write(CFG_PATTERN_LENGTH, ADDR_W'(len_cfg));
    cfg_write(CFG_BASE_ADDRESS, base_v);
    for (int s = 0; s < eff_len; s++) begin
      set_phase();
      push_item(load_item(s, $urandom_range(255), $urandom_range(3) == 0));
      random_items++;
    end
    if (long_round) begin
      run_stream(eff_len, eff_len + $urandom_range(20), 1'b1, 1'b1);
    end else begin
      n_streams = $urandom_range(1, 3);
      for (int s = 0; s < n_streams; s++) begin
        n = $urandom_range(1, eff_len + 12);
        // the final stream sometimes runs on into the next setting
        run_stream(eff_len, n, $urandom_range(99) < 60,
                   s < n_streams - 1 || $urandom_range(9) != 0);
      end
    end
  endtask

  initial begin
    int round_no;
    round_no = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // every slot gets a defined value before the first scanned byte
    for (int s = 0; s < PATTERN_MAX; s++)
      push_item(load_item(s, $urandom_range(255), 1'($urandom_range(1))));

    // empty pattern never matches
    settle();
    cfg_write(CFG_PATTERN_LENGTH, '0);
    cfg_write(CFG_BASE_ADDRESS, '0);
    push_item(scan_item(8'h00, 1'b0));
    push_item(scan_item(8'hff, 1'b0));
    push_item(scan_item(8'h00, 1'b1));

    // pattern 00 ?? ff at the top of the address space
    settle();
    cfg_write(CFG_PATTERN_LENGTH, ADDR_W'(3));
    cfg_write(CFG_BASE_ADDRESS, '1);
    push_item(load_item(0, 8'h00, 1'b0));
    push_item(load_item(1, 8'hff, 1'b1));
    push_item(load_item(2, 8'hff, 1'b0));
    // match completes on the last byte
    push_item(scan_item(8'h00, 1'b0));
    push_item(scan_item(8'h12, 1'b0));
    push_item(scan_item(8'hff, 1'b1));
    // match at offset one wraps the address, trailing bytes are dropped
    push_item(scan_item(8'h55, 1'b0));
    push_item(scan_item(8'h00, 1'b0));
    push_item(scan_item(8'hab, 1'b0));
    push_item(scan_item(8'hff, 1'b0));
    push_item(scan_item(8'h00, 1'b0));
    push_item(scan_item(8'h01, 1'b1));
    // stream shorter than the pattern
    push_item(scan_item(8'h00, 1'b0));
    push_item(scan_item(8'hff, 1'b1));

    // long receiver hold-off: output queue fills and the input must stall
    settle();
    fork
      hold_receiver(80);
      repeat (40) push_item(scan_item($urandom_range(255), 1'b1));
    join

    // the directed part above sends about three hundred transactions
    while (random_items < 900) begin
      run_round(round_no);
      round_no++;
    end

    settle();
    repeat (8) @(negedge clk);
    $display("covered %0d pattern loads and %0d scanned bytes over %0d settings",
             sb.loads, sb.scans, round_no + 3);
    $display("checked %0d results (%0d found) under all idle mixes and a full output",
             sb.results, sb.hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
